// ===== rtl/yhpid_pkg.sv =====
package yhpid_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int DRIVE_LIMIT_DEF = 1000;
  localparam int PWM_LIMIT_DEF   = 255;

  localparam int HEADING_W = 16;
  localparam int TD_W      = 20;
  localparam int CMD_W     = 9;
  localparam int GAIN_W    = 16;
  localparam int DB_W      = 14;
  localparam int DRV_OUT_W = 10;
  localparam int TURN_OUT_W = 9;
  localparam int REP_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam int DP_W   = 64;
  localparam int CNT_W  = 6;
  localparam int MPL_W  = 20;
  localparam int INTEG_W = 32;
  localparam int DERIV_W = 42;
  localparam int SUM_FRAC = 14;

  localparam int HALF_TURN   = 11520;
  localparam int FULL_TURN   = 23040;
  localparam int MILLI_DIV   = 1000;
  localparam int DERIV_SCALE = 1000000;
  localparam int DRIVE_SAT   = 510;
  localparam logic [DP_W-1:0] DERIV_CAP = 64'd1 << 40;

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd614;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd128;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd90;
  localparam logic [DB_W-1:0]   DEAD_BAND_RST  = 14'd64;

  localparam logic [CMD_W-1:0]        CMD_NEG_FULL = 9'h100;
  localparam logic signed [CMD_W-1:0] CMD_NEG_SAT  = -9'sd255;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_INT_MUL,
    ST_INT_DIV,
    ST_INT_ACC,
    ST_DER_MUL,
    ST_DER_DIV,
    ST_DER_SAT,
    ST_KI_MUL,
    ST_KI_DIV,
    ST_KI_ACC,
    ST_KP_MUL,
    ST_KP_ACC,
    ST_KD_MUL,
    ST_KD_ACC,
    ST_CLAMP,
    ST_SCL_MUL,
    ST_SCL_DIV,
    ST_FIN
  } yhpid_state_t;

endpackage

// ===== rtl/yaw_hold_pid_differential_drive_unit.sv =====
// Yaw-hold PID turn controller. A mode-1 transaction stores the base sideward
// command and a first heading sample latches the target; both produce no
// result. Every later heading sample occupies the block from acceptance until
// the next input can be taken: a shift-and-add multiplier retires one
// multiplier bit per cycle (six products), a restoring divider retires one
// quotient bit per cycle (four quotients), and eight steps form the error,
// the accumulations, the derivative cap, the clamp and the result. The result
// waits in an output register, so the next sample may be accepted while it is
// still pending; the final step only stalls if the previous result has not
// yet been taken.
module yaw_hold_pid_differential_drive_unit
  import yhpid_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int DRIVE_LIMIT = DRIVE_LIMIT_DEF,
  parameter int PWM_LIMIT   = PWM_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // heading [15:0], time_delta [35:16], sideward_command [44:36], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode [0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // front_drive [9:0], back_drive [19:10], turn_drive [28:20],
  // heading_error [43:29], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data
);

  localparam int ERR_W  = (ANGLE_WIDTH + 2 > 17) ? ANGLE_WIDTH + 2 : 17;
  localparam int DIFF_W = ANGLE_WIDTH + 1;
  localparam int LIM    = DRIVE_LIMIT << SUM_FRAC;
  localparam int LIM_W  = $clog2(LIM + 1);
  localparam int DEN_W  = (LIM_W > TD_W) ? LIM_W : TD_W;
  localparam int TURN_W = $clog2(PWM_LIMIT + 1) + 1;
  localparam int DRV_W  = ((TURN_W > DRV_OUT_W) ? TURN_W : DRV_OUT_W) + 1;

  localparam logic signed [ERR_W-1:0] HALF_E = ERR_W'(HALF_TURN);
  localparam logic signed [ERR_W-1:0] FULL_E = ERR_W'(FULL_TURN);
  localparam logic signed [DP_W-1:0]  INT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [DP_W-1:0]  INT_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [DRV_W-1:0] DRV_SAT_E = DRV_W'(DRIVE_SAT);

  yhpid_state_t state_r, state_nxt;

  logic [GAIN_W-1:0]             gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [DB_W-1:0]               dead_band_r;
  logic signed [ANGLE_WIDTH-1:0] target_r, target_nxt;
  logic signed [ANGLE_WIDTH-1:0] prev_r, prev_nxt;
  logic                          latched_r, latched_nxt;
  logic signed [INTEG_W-1:0]     integ_r, integ_nxt;
  logic signed [CMD_W-1:0]       base_r, base_nxt;

  logic signed [ANGLE_WIDTH-1:0] head_r, head_nxt;
  logic [TD_W-1:0]               dt_r, dt_nxt;
  logic signed [ERR_W-1:0]       err_r, err_nxt;
  logic signed [DIFF_W-1:0]      diff_r, diff_nxt;
  logic signed [DERIV_W-1:0]     deriv_r, deriv_nxt;
  logic signed [DP_W-1:0]        sum_r, sum_nxt;

  logic [DP_W-1:0]  acc_r, acc_nxt;
  logic [DP_W-1:0]  mcand_r, mcand_nxt;
  logic [MPL_W-1:0] mplier_r, mplier_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [DRV_OUT_W-1:0]        out_front_r, out_front_nxt;
  logic [DRV_OUT_W-1:0]        out_back_r, out_back_nxt;
  logic [TURN_OUT_W-1:0]       out_turn_r, out_turn_nxt;
  logic [REP_W-1:0]            out_rep_r, out_rep_nxt;

  logic                  in_go, in_mul, in_div, mul_done, div_done, out_free;
  logic [DP_W-1:0]       mul_sum, div_quo;
  logic [DEN_W:0]        rem_sh;
  logic                  div_ge;

  logic [DP_W-1:0]               head_ext;
  logic signed [CMD_W-1:0]       cmd_in;
  logic [TD_W-1:0]               dt_in;
  logic signed [ERR_W-1:0]       tgt_x, tgt_w, tgt_e, head_e, err0, alt0;
  logic signed [ANGLE_WIDTH-1:0] tgt_new;
  logic [ERR_W-1:0]              err0_mag, alt0_mag, err_mag;
  logic                          err_neg, diff_neg, integ_neg, deriv_neg, sum_neg;
  logic [DIFF_W-1:0]             diff_mag;
  logic [INTEG_W:0]              integ_mag;
  logic [DERIV_W-1:0]            deriv_mag;
  logic [DP_W-1:0]               sum_mag, quo_cap;
  logic signed [DP_W-1:0]        quo_s, err_term, integ_sum;
  logic signed [TURN_W-1:0]      turn_s;
  logic signed [DRV_W-1:0]       turn_e, base_e, front_s, back_s;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_rep_r, out_turn_r, out_back_r, out_front_r};

  assign in_go    = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_mul   = state_r inside {ST_INT_MUL, ST_DER_MUL, ST_KI_MUL, ST_KP_MUL,
                                    ST_KD_MUL, ST_SCL_MUL};
  assign in_div   = state_r inside {ST_INT_DIV, ST_DER_DIV, ST_KI_DIV, ST_SCL_DIV};
  assign mul_done = (cnt_r == CNT_W'(MPL_W - 1));
  assign div_done = (cnt_r == CNT_W'(DP_W - 1));

  assign mul_sum = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign rem_sh  = {rem_r, acc_r[DP_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, den_r});
  assign div_quo = {acc_r[DP_W-2:0], div_ge};

  assign head_ext = {{(DP_W-HEADING_W){in_tdata[HEADING_W-1]}}, in_tdata[HEADING_W-1:0]};
  assign cmd_in   = in_tdata[HEADING_W+TD_W +: CMD_W];
  assign dt_in    = in_tdata[HEADING_W +: TD_W];

  always_comb begin
    tgt_x = {{(ERR_W-ANGLE_WIDTH){target_r[ANGLE_WIDTH-1]}}, target_r};
    if (tgt_x >= HALF_E) begin
      tgt_w = tgt_x - FULL_E;
    end else if (tgt_x <= -HALF_E) begin
      tgt_w = tgt_x + FULL_E;
    end else begin
      tgt_w = tgt_x;
    end
    tgt_new  = tgt_w[ANGLE_WIDTH-1:0];
    tgt_e    = {{(ERR_W-ANGLE_WIDTH){tgt_new[ANGLE_WIDTH-1]}}, tgt_new};
    head_e   = {{(ERR_W-ANGLE_WIDTH){head_r[ANGLE_WIDTH-1]}}, head_r};
    err0     = tgt_e - head_e;
    alt0     = err0[ERR_W-1] ? err0 + FULL_E : err0 - FULL_E;
    err0_mag = err0[ERR_W-1] ? -err0 : err0;
    alt0_mag = alt0[ERR_W-1] ? -alt0 : alt0;

    err_neg   = err_r[ERR_W-1];
    err_mag   = err_neg ? -err_r : err_r;
    diff_neg  = diff_r[DIFF_W-1];
    diff_mag  = diff_neg ? -diff_r : diff_r;
    integ_neg = integ_r[INTEG_W-1];
    integ_mag = integ_neg ? -{integ_r[INTEG_W-1], integ_r} : {1'b0, integ_r};
    deriv_neg = deriv_r[DERIV_W-1];
    deriv_mag = deriv_neg ? -deriv_r : deriv_r;
    sum_neg   = sum_r[DP_W-1];
    sum_mag   = sum_neg ? -sum_r : sum_r;

    quo_s     = $signed(acc_r);
    quo_cap   = (acc_r > DERIV_CAP) ? DERIV_CAP : acc_r;
    err_term  = err_neg ? -quo_s : quo_s;
    integ_sum = {{(DP_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r} + err_term;

    turn_s = sum_neg ? -$signed(acc_r[TURN_W-1:0]) : $signed(acc_r[TURN_W-1:0]);
    if (err_mag < ERR_W'(dead_band_r)) begin
      turn_s = '0;
    end
    turn_e  = {{(DRV_W-TURN_W){turn_s[TURN_W-1]}}, turn_s};
    base_e  = {{(DRV_W-CMD_W){base_r[CMD_W-1]}}, base_r};
    front_s = base_e + turn_e;
    back_s  = base_e - turn_e;
    if (front_s > DRV_SAT_E) begin
      front_s = DRV_SAT_E;
    end else if (front_s < -DRV_SAT_E) begin
      front_s = -DRV_SAT_E;
    end
    if (back_s > DRV_SAT_E) begin
      back_s = DRV_SAT_E;
    end else if (back_s < -DRV_SAT_E) begin
      back_s = -DRV_SAT_E;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    prev_nxt      = prev_r;
    latched_nxt   = latched_r;
    integ_nxt     = integ_r;
    base_nxt      = base_r;
    head_nxt      = head_r;
    dt_nxt        = dt_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    deriv_nxt     = deriv_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_front_nxt = out_front_r;
    out_back_nxt  = out_back_r;
    out_turn_nxt  = out_turn_r;
    out_rep_nxt   = out_rep_r;

    if (in_mul) begin
      acc_nxt    = mul_sum;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
    end
    if (in_div) begin
      acc_nxt = div_quo;
      rem_nxt = div_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          if (in_tuser) begin
            base_nxt = (cmd_in == CMD_NEG_FULL) ? CMD_NEG_SAT : cmd_in;
          end else if (!latched_r) begin
            target_nxt  = head_ext[ANGLE_WIDTH-1:0];
            prev_nxt    = head_ext[ANGLE_WIDTH-1:0];
            latched_nxt = 1'b1;
          end else begin
            head_nxt  = head_ext[ANGLE_WIDTH-1:0];
            dt_nxt    = (dt_in == '0) ? TD_W'(1) : dt_in;
            state_nxt = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        target_nxt = tgt_new;
        err_nxt    = (alt0_mag < err0_mag) ? alt0 : err0;
        diff_nxt   = {head_r[ANGLE_WIDTH-1], head_r} - {prev_r[ANGLE_WIDTH-1], prev_r};
        prev_nxt   = head_r;
        acc_nxt    = '0;
        mcand_nxt  = DP_W'((alt0_mag < err0_mag) ? alt0_mag : err0_mag);
        mplier_nxt = dt_r;
        cnt_nxt    = '0;
        state_nxt  = ST_INT_MUL;
      end
      ST_INT_MUL: begin
        if (mul_done) begin
          rem_nxt   = '0;
          den_nxt   = DEN_W'(MILLI_DIV);
          cnt_nxt   = '0;
          state_nxt = ST_INT_DIV;
        end
      end
      ST_INT_DIV: begin
        if (div_done) begin
          state_nxt = ST_INT_ACC;
        end
      end
      ST_INT_ACC: begin
        if (integ_sum > INT_MAX) begin
          integ_nxt = INT_MAX[INTEG_W-1:0];
        end else if (integ_sum < INT_MIN) begin
          integ_nxt = INT_MIN[INTEG_W-1:0];
        end else begin
          integ_nxt = integ_sum[INTEG_W-1:0];
        end
        acc_nxt    = '0;
        mcand_nxt  = DP_W'(diff_mag);
        mplier_nxt = MPL_W'(DERIV_SCALE);
        cnt_nxt    = '0;
        state_nxt  = ST_DER_MUL;
      end
      ST_DER_MUL: begin
        if (mul_done) begin
          rem_nxt   = '0;
          den_nxt   = DEN_W'(dt_r);
          cnt_nxt   = '0;
          state_nxt = ST_DER_DIV;
        end
      end
      ST_DER_DIV: begin
        if (div_done) begin
          state_nxt = ST_DER_SAT;
        end
      end
      ST_DER_SAT: begin
        deriv_nxt  = diff_neg ? -$signed(quo_cap[DERIV_W-1:0])
                              : $signed(quo_cap[DERIV_W-1:0]);
        acc_nxt    = '0;
        mcand_nxt  = DP_W'(integ_mag);
        mplier_nxt = MPL_W'(gain_integ_r);
        cnt_nxt    = '0;
        state_nxt  = ST_KI_MUL;
      end
      ST_KI_MUL: begin
        if (mul_done) begin
          rem_nxt   = '0;
          den_nxt   = DEN_W'(MILLI_DIV);
          cnt_nxt   = '0;
          state_nxt = ST_KI_DIV;
        end
      end
      ST_KI_DIV: begin
        if (div_done) begin
          state_nxt = ST_KI_ACC;
        end
      end
      ST_KI_ACC: begin
        sum_nxt    = integ_neg ? -quo_s : quo_s;
        acc_nxt    = '0;
        mcand_nxt  = DP_W'(err_mag);
        mplier_nxt = MPL_W'(gain_prop_r);
        cnt_nxt    = '0;
        state_nxt  = ST_KP_MUL;
      end
      ST_KP_MUL: begin
        if (mul_done) begin
          state_nxt = ST_KP_ACC;
        end
      end
      ST_KP_ACC: begin
        sum_nxt    = sum_r + err_term;
        acc_nxt    = '0;
        mcand_nxt  = DP_W'(deriv_mag);
        mplier_nxt = MPL_W'(gain_deriv_r);
        cnt_nxt    = '0;
        state_nxt  = ST_KD_MUL;
      end
      ST_KD_MUL: begin
        if (mul_done) begin
          state_nxt = ST_KD_ACC;
        end
      end
      ST_KD_ACC: begin
        sum_nxt   = sum_r + (deriv_neg ? -quo_s : quo_s);
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        acc_nxt    = '0;
        mcand_nxt  = (sum_mag > DP_W'(LIM)) ? DP_W'(LIM) : sum_mag;
        mplier_nxt = MPL_W'(PWM_LIMIT);
        cnt_nxt    = '0;
        state_nxt  = ST_SCL_MUL;
      end
      ST_SCL_MUL: begin
        if (mul_done) begin
          rem_nxt   = '0;
          den_nxt   = DEN_W'(LIM);
          cnt_nxt   = '0;
          state_nxt = ST_SCL_DIV;
        end
      end
      ST_SCL_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_front_nxt = front_s[DRV_OUT_W-1:0];
          out_back_nxt  = back_s[DRV_OUT_W-1:0];
          out_turn_nxt  = turn_e[TURN_OUT_W-1:0];
          if (err_r > HALF_E) begin
            out_rep_nxt = HALF_E[REP_W-1:0];
          end else if (err_r < -HALF_E) begin
            out_rep_nxt = -HALF_E[REP_W-1:0];
          end else begin
            out_rep_nxt = err_r[REP_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      target_r     <= '0;
      prev_r       <= '0;
      latched_r    <= 1'b0;
      integ_r      <= '0;
      base_r       <= '0;
      out_valid_r  <= 1'b0;
      gain_prop_r  <= GAIN_PROP_RST;
      gain_integ_r <= GAIN_INTEG_RST;
      gain_deriv_r <= GAIN_DERIV_RST;
      dead_band_r  <= DEAD_BAND_RST;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      prev_r      <= prev_nxt;
      latched_r   <= latched_nxt;
      integ_r     <= integ_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GAIN_PROP:  gain_prop_r  <= cfg_data;
          CFG_GAIN_INTEG: gain_integ_r <= cfg_data;
          CFG_GAIN_DERIV: gain_deriv_r <= cfg_data;
          CFG_DEAD_BAND:  dead_band_r  <= cfg_data[DB_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r      <= head_nxt;
    dt_r        <= dt_nxt;
    err_r       <= err_nxt;
    diff_r      <= diff_nxt;
    deriv_r     <= deriv_nxt;
    sum_r       <= sum_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    cnt_r       <= cnt_nxt;
    out_front_r <= out_front_nxt;
    out_back_r  <= out_back_nxt;
    out_turn_r  <= out_turn_nxt;
    out_rep_r   <= out_rep_nxt;
  end

endmodule

// ===== dv/yaw_hold_pid_differential_drive_unit_test.sv =====
module yaw_hold_pid_differential_drive_unit_test;
  import yhpid_pkg::*;

  localparam int     CYCLE_LIMIT = 5000000;
  localparam int     BLOCK_LAT   = 400;
  localparam longint INTEG_MAX   = (longint'(1) <<< 31) - 1;
  localparam longint INTEG_MIN   = -(longint'(1) <<< 31);
  localparam longint DERIV_LIM   = longint'(1) <<< 40;
  localparam longint SUM_LIM     = longint'(DRIVE_LIMIT_DEF) <<< SUM_FRAC;

  typedef struct {
    bit                          mode;
    logic signed [HEADING_W-1:0] heading;
    logic [TD_W-1:0]             dt;
    logic signed [CMD_W-1:0]     cmd;
    bit                          drain_first;
  } sample_t;

  // Packed from the top down, so that the front drive sits in the lowest bits.
  typedef struct packed {
    logic signed [REP_W-1:0]      herr;
    logic signed [TURN_OUT_W-1:0] turn;
    logic signed [DRV_OUT_W-1:0]  back;
    logic signed [DRV_OUT_W-1:0]  front;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [GAIN_W-1:0]     cfg_data = '0;

  sample_t sample_queue[$];
  drive_t  drive_expect[$];
  sample_t cur_sample;
  logic    in_fire = 1'b0;
  int      send_gap = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      gap_pct = 30;
  int      stall_pct = 2;
  int      results_seen = 0;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      walk_ofs = 0;

  longint gain_p = GAIN_PROP_RST;
  longint gain_i = GAIN_INTEG_RST;
  longint gain_d = GAIN_DERIV_RST;
  longint dband = DEAD_BAND_RST;
  longint target_hd = 0;
  longint prev_hd = 0;
  longint integ_acc = 0;
  longint base_cmd = 0;
  bit     target_set = 1'b0;

  yaw_hold_pid_differential_drive_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_idle();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 6);
    return $urandom_range(20, 500);
  endfunction

  task automatic log_fault(input string what, input longint want, input longint seen);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, seen);
    fail_count++;
  endtask

  task automatic predict_drive(input sample_t s);
    longint h, dt, err, alt, deriv, sum, turn, front, back, rep;
    logic signed [HEADING_W-1:0] t16;
    drive_t r;
    if (s.mode) begin
      base_cmd = clamp64(longint'(s.cmd), -PWM_LIMIT_DEF, PWM_LIMIT_DEF);
      return;
    end
    h = longint'(s.heading);
    if (!target_set) begin
      target_hd = h;
      prev_hd = h;
      target_set = 1'b1;
      return;
    end
    dt = longint'(s.dt);
    if (dt == 0) dt = 1;
    if (target_hd >= HALF_TURN) target_hd -= FULL_TURN;
    else if (target_hd <= -HALF_TURN) target_hd += FULL_TURN;
    t16 = target_hd[HEADING_W-1:0];
    target_hd = t16;
    err = target_hd - h;
    alt = (err < 0) ? err + FULL_TURN : err - FULL_TURN;
    if ((alt < 0 ? -alt : alt) < (err < 0 ? -err : err)) err = alt;
    integ_acc = clamp64(integ_acc + (err * dt) / MILLI_DIV, INTEG_MIN, INTEG_MAX);
    deriv = clamp64(h - prev_hd, -DERIV_LIM, DERIV_LIM);
    deriv = clamp64((deriv * DERIV_SCALE) / dt, -DERIV_LIM, DERIV_LIM);
    prev_hd = h;
    sum = gain_p * err + gain_d * deriv + (gain_i * integ_acc) / MILLI_DIV;
    sum = clamp64(sum, -SUM_LIM, SUM_LIM);
    turn = clamp64((sum * PWM_LIMIT_DEF) / SUM_LIM, -PWM_LIMIT_DEF, PWM_LIMIT_DEF);
    if (err < dband && err > -dband) turn = 0;
    front = clamp64(base_cmd + turn, -DRIVE_SAT, DRIVE_SAT);
    back = clamp64(base_cmd - turn, -DRIVE_SAT, DRIVE_SAT);
    rep = clamp64(err, -HALF_TURN, HALF_TURN);
    r.front = front[DRV_OUT_W-1:0];
    r.back = back[DRV_OUT_W-1:0];
    r.turn = turn[TURN_OUT_W-1:0];
    r.herr = rep[REP_W-1:0];
    drive_expect.push_back(r);
  endtask

  always @(posedge clk) begin
    drive_t seen, want;
    if (rst_n) begin
      in_fire <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        seen = out_tdata[$bits(drive_t)-1:0];
        results_seen++;
        if (drive_expect.size() == 0) begin
          log_fault("drive result with nothing pending", 0, longint'(seen.turn));
        end else begin
          want = drive_expect.pop_front();
          if (seen.front !== want.front)
            log_fault("front_drive", longint'(want.front), longint'(seen.front));
          if (seen.back !== want.back)
            log_fault("back_drive", longint'(want.back), longint'(seen.back));
          if (seen.turn !== want.turn)
            log_fault("turn_drive", longint'(want.turn), longint'(seen.turn));
          if (seen.herr !== want.herr)
            log_fault("heading_error", longint'(want.herr), longint'(seen.herr));
        end
      end
      if (in_tvalid && in_tready) predict_drive(cur_sample);
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (sample_queue.size() != 0 &&
                   !(sample_queue[0].drain_first && drive_expect.size() != 0)) begin
        cur_sample = sample_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_sample.mode;
        in_tdata <= {3'b000, cur_sample.cmd, cur_sample.dt, cur_sample.heading};
        send_gap = ($urandom_range(0, 99) < gap_pct) ? pick_idle() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Random stalls; one long hold-off lets the block fill up and stall its input side.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 150) begin
        out_tready <= 1'b0;
        hold_left = 3000;
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        hold_left = pick_idle();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GAIN_PROP:  gain_p = val;
      CFG_GAIN_INTEG: gain_i = val;
      CFG_GAIN_DERIV: gain_d = val;
      CFG_DEAD_BAND:  dband = val[DB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] db);
    write_reg(CFG_GAIN_PROP, kp);
    write_reg(CFG_GAIN_INTEG, ki);
    write_reg(CFG_GAIN_DERIV, kd);
    write_reg(CFG_DEAD_BAND, db);
  endtask

  task automatic settle_block();
    while (sample_queue.size() != 0 || in_tvalid || drive_expect.size() != 0)
      @(posedge clk);
    repeat (BLOCK_LAT) @(posedge clk);
  endtask

  task automatic queue_sample(input bit mode, input int heading, input int dt,
                              input int cmd, input bit drain_first);
    sample_t s;
    s.mode = mode;
    s.heading = HEADING_W'(heading);
    s.dt = TD_W'(dt);
    s.cmd = CMD_W'(cmd);
    s.drain_first = drain_first;
    sample_queue.push_back(s);
  endtask

  // Headings wander around the target at half a turn, with some full-range noise.
  task automatic queue_walk(input int count);
    sample_t s;
    int      roll;
    int      pace;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      s.drain_first = 1'b0;
      s.heading = HEADING_W'($urandom);
      s.dt = TD_W'($urandom);
      s.cmd = CMD_W'($urandom);
      s.mode = (roll < 8);
      if (roll >= 16) begin
        walk_ofs += int'($urandom_range(0, 800)) - 400;
        if (walk_ofs > 8000) walk_ofs = 8000;
        if (walk_ofs < -8000) walk_ofs = -8000;
        s.heading = HEADING_W'(HALF_TURN + walk_ofs);
        pace = $urandom_range(0, 9);
        if (pace < 8) s.dt = TD_W'($urandom_range(1000, 50000));
        else if (pace == 8) s.dt = TD_W'($urandom_range(0, 100));
      end
      sample_queue.push_back(s);
    end
  endtask

  // A steady large error over the longest time step drives the integral to its limit.
  task automatic queue_windup(input int count, input int offset);
    for (int i = 0; i < count; i++)
      queue_sample(1'b0, HALF_TURN + offset, (1 << TD_W) - 1, $urandom, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_sample(1'b1, $urandom, $urandom, -256, 1'b0);
    queue_sample(1'b0, HALF_TURN, $urandom, $urandom, 1'b0);
    queue_sample(1'b0, HALF_TURN + 10, 0, $urandom, 1'b0);
    queue_sample(1'b0, -32768, 1, $urandom, 1'b0);
    queue_sample(1'b0, 32767, (1 << TD_W) - 1, $urandom, 1'b0);
    queue_sample(1'b0, HALF_TURN + 63, 1000, $urandom, 1'b0);
    queue_sample(1'b0, HALF_TURN + 64, 1000, $urandom, 1'b0);
    queue_sample(1'b0, HALF_TURN - 64, 1000, $urandom, 1'b0);
    queue_sample(1'b0, HALF_TURN - 63, 1000, $urandom, 1'b0);
    queue_sample(1'b1, $urandom, $urandom, 255, 1'b0);
    queue_sample(1'b0, 0, 20000, $urandom, 1'b0);
    queue_sample(1'b0, HALF_TURN + 3000, 1, $urandom, 1'b0);
    queue_sample(1'b1, $urandom, $urandom, -255, 1'b0);
    queue_sample(1'b0, HALF_TURN - 3000, 1, $urandom, 1'b0);
    queue_sample(1'b1, $urandom, $urandom, 0, 1'b0);
    queue_sample(1'b0, HALF_TURN, (1 << TD_W) - 1, $urandom, 1'b0);
    queue_walk(250);
    settle_block();

    write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, GAIN_W'(HALF_TURN));
    queue_walk(250);
    settle_block();

    gap_pct = 0;
    stall_pct = 0;
    write_gains(16'd0, 16'd0, 16'd0, 16'd0);
    queue_walk(200);
    settle_block();

    gap_pct = 30;
    stall_pct = 3;
    write_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(1, 200)),
                GAIN_W'($urandom_range(0, 2000)), GAIN_W'($urandom_range(0, 2000)));
    queue_windup(200, 11000);
    queue_windup(186, -11000);
    settle_block();

    write_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                GAIN_W'($urandom_range(0, HALF_TURN)));
    queue_walk(150);
    queue_sample(1'b0, HALF_TURN + 200, 20000, $urandom, 1'b1);
    queue_walk(200);

    while (sample_queue.size() != 0 || in_tvalid) @(posedge clk);
    for (int n = 0; n < 20000 && drive_expect.size() != 0; n++) @(posedge clk);
    repeat (BLOCK_LAT) @(posedge clk);
    while (drive_expect.size() != 0) begin
      log_fault("drive result never arrived", longint'(drive_expect[0].turn), 0);
      void'(drive_expect.pop_front());
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/yhpid_pkg.sv
rtl/yaw_hold_pid_differential_drive_unit.sv
dv/yaw_hold_pid_differential_drive_unit_test.sv
